// File: rtl/core/rmsag_pkg.sv
package rmsag_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_BLOCK   = 4096;
  localparam int FRAME_BITS  = 13;
  localparam int COEFF_BITS  = 24;
  localparam int GAIN_BITS   = 19;
  localparam int MS_BITS     = 32;
  localparam int SUM_BITS    = 64;
  localparam int SUM_SHIFT   = 14;
  localparam int CFG_BITS    = 24;
  localparam int CFG_IDX_BITS = 2;

  localparam int MUL_A_BITS  = COEFF_BITS + 1;
  localparam int MUL_B_BITS  = MS_BITS;
  localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;

  localparam int DIV_CNT_LAST  = SUM_BITS;
  localparam int RATIO_BITS    = 36;
  localparam int ROOT_BITS     = RATIO_BITS + 1;
  localparam int ROOT_CNT_LAST = RATIO_BITS / 2 - 1;

  localparam logic [GAIN_BITS-1:0]  GAIN_MIN = GAIN_BITS'(16384);
  localparam logic [GAIN_BITS-1:0]  GAIN_MAX = GAIN_BITS'(262144);
  localparam logic [GAIN_BITS-1:0]  GAIN_ONE = GAIN_BITS'(65536);
  localparam logic [MS_BITS-1:0]    MS_RESET = MS_BITS'(4295);
  localparam logic [COEFF_BITS-1:0] COEFF_RESET = COEFF_BITS'(16776051);

  localparam int    STEP_Q16    = 3277;
  localparam int    STEP_BIAS   = 1 << GAIN_BITS;
  localparam longint STEP_OFFSET = 64'(32768) - 64'(STEP_Q16) * 64'(STEP_BIAS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SMOOTH,
    ST_TARGET,
    ST_SQRT,
    ST_STEP,
    ST_HOLD
  } state_t;

  typedef enum logic [1:0] {
    DIV_DRY,
    DIV_WET,
    DIV_RATIO
  } div_sel_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEVEL_COEFF,
    REG_AUTO_GAIN_ON,
    REG_DELTA_ON,
    REG_CHANNEL_COUNT
  } reg_index_t;

endpackage

// File: rtl/core/rms_auto_gain_match.sv
// Channel   Signals                                    Handshake
// config    cfg_we, cfg_index, cfg_data                write on cfg_we, no wait
// input     dry_left/right, wet_left/right, block_end  in_valid / in_ready
// output    match_gain, apply_gain                     out_valid / out_ready
//
// A frame is accepted, then squared one square per cycle through the shared 25x32
// multiplier, four squares with two channels and two with one. A block-end frame adds
// the two 64-step mean divisions, smoothing and the gain step, plus the 64-step ratio
// division and 18-step square root when auto gain is on and dry is under 16x wet.
// Synchronous reset clears state, sums and registers to their defaults.
// The next frame is taken while a result waits; a second result waits for out_ready.
module rms_auto_gain_match (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [rmsag_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [rmsag_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [rmsag_pkg::SAMPLE_BITS-1:0] dry_left,
  input  logic signed [rmsag_pkg::SAMPLE_BITS-1:0] dry_right,
  input  logic signed [rmsag_pkg::SAMPLE_BITS-1:0] wet_left,
  input  logic signed [rmsag_pkg::SAMPLE_BITS-1:0] wet_right,
  input  logic                                   block_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rmsag_pkg::GAIN_BITS-1:0]        match_gain,
  output logic                                   apply_gain
);

  localparam int SB = rmsag_pkg::SAMPLE_BITS;
  localparam int GB = rmsag_pkg::GAIN_BITS;
  localparam int MB = rmsag_pkg::MS_BITS;
  localparam int PB = rmsag_pkg::PROD_BITS;
  localparam int RB = rmsag_pkg::ROOT_BITS;
  localparam int QB = rmsag_pkg::RATIO_BITS;

  rmsag_pkg::state_t   state, state_next;
  rmsag_pkg::div_sel_t div_sel;

  logic [rmsag_pkg::COEFF_BITS-1:0] level_coeff;
  logic                             auto_gain_on;
  logic                             delta_on;
  logic [1:0]                       channel_count;

  logic [3:0][SB-1:0]                mag;
  logic                              frame_end;
  logic                              stereo;
  logic [rmsag_pkg::SUM_BITS-1:0]    dry_square_sum;
  logic [rmsag_pkg::SUM_BITS-1:0]    wet_square_sum;
  logic [rmsag_pkg::FRAME_BITS-1:0]  frame_count;
  logic [MB-1:0]                     dry_mean_square;
  logic [MB-1:0]                     wet_mean_square;
  logic [MB-1:0]                     dry_mean;
  logic [MB-1:0]                     wet_mean;
  logic [GB-1:0]                     smoothed_gain;
  logic [GB-1:0]                     target;
  logic [6:0]                        cnt;

  logic [rmsag_pkg::MUL_A_BITS-1:0]  mul_a;
  logic [rmsag_pkg::MUL_B_BITS-1:0]  mul_b;
  logic [PB-1:0]                     prod;
  logic [PB-1:0]                     acc;
  logic [PB:0]                       smooth_sum;

  logic [MB-1:0]                     div_rem;
  logic [rmsag_pkg::SUM_BITS-1:0]    div_quo;
  logic [MB-1:0]                     div_den;
  logic [MB:0]                       div_shift;
  logic                              div_bit;
  logic [MB-1:0]                     div_rem_next;
  logic [MB-1:0]                     mean_sat;

  logic [QB-1:0]                     sq_v;
  logic [RB-1:0]                     sq_r;
  logic [RB-1:0]                     sq_b;
  logic [RB-1:0]                     sq_rb;
  logic                              sq_take;
  logic [RB-1:0]                     sq_r_next;
  logic [GB-1:0]                     root_clamped;

  logic                              in_fire;
  logic                              drop;
  logic [2:0]                        sq_last;
  logic [rmsag_pkg::FRAME_BITS:0]    block_div;
  logic [rmsag_pkg::FRAME_BITS-1:0]  frame_n;
  logic [MB-1:0]                     wet_den;
  logic                              gain_big;
  logic [GB:0]                       gain_diff;
  logic signed [33:0]                step_tmp;
  logic signed [33:0]                step_shift;
  logic                              out_free;
  logic [1:0]                        acc_idx;

  function automatic logic [SB-1:0] magnitude(input logic signed [SB-1:0] x);
    magnitude = x[SB-1] ? SB'(-x) : x;
  endfunction

  assign in_fire  = in_valid && in_ready;
  assign drop     = !block_end && (frame_count >= rmsag_pkg::FRAME_BITS'(rmsag_pkg::MAX_BLOCK - 1));
  assign sq_last  = stereo ? 3'd4 : 3'd2;
  assign frame_n  = frame_count + 1'b1;
  assign block_div = stereo ? {frame_n, 1'b0} : {1'b0, frame_n};
  assign wet_den  = (wet_mean_square == '0) ? MB'(1) : wet_mean_square;
  assign gain_big = {4'b0, dry_mean_square} >= {wet_den, 4'b0};
  assign out_free = !out_valid || out_ready;
  assign acc_idx  = 2'(cnt - 7'd1);

  // divider step
  assign div_shift    = {div_rem, div_quo[rmsag_pkg::SUM_BITS-1]};
  assign div_bit      = div_shift >= {1'b0, div_den};
  assign div_rem_next = div_bit ? MB'(div_shift - {1'b0, div_den}) : div_shift[MB-1:0];
  assign mean_sat     = (div_quo[rmsag_pkg::SUM_BITS-1:MB] != '0) ? '1 : div_quo[MB-1:0];

  // square root step
  assign sq_rb     = sq_r + sq_b;
  assign sq_take   = {1'b0, sq_v} >= sq_rb;
  assign sq_r_next = sq_take ? ((sq_r >> 1) + sq_b) : (sq_r >> 1);
  assign root_clamped = (sq_r_next < RB'(rmsag_pkg::GAIN_MIN)) ? rmsag_pkg::GAIN_MIN :
                        (sq_r_next > RB'(rmsag_pkg::GAIN_MAX)) ? rmsag_pkg::GAIN_MAX :
                        sq_r_next[GB-1:0];

  assign smooth_sum = {1'b0, acc} + {1'b0, prod} + (PB+1)'(1 << 23);
  assign gain_diff  = {1'b0, target} - {1'b0, smoothed_gain} + (GB+1)'(rmsag_pkg::STEP_BIAS);
  assign step_tmp   = $signed({2'b0, prod[31:0]}) + 34'(rmsag_pkg::STEP_OFFSET);
  assign step_shift = step_tmp >>> 16;

  always_comb begin
    state_next = state;
    case (state)
      rmsag_pkg::ST_IDLE: begin
        if (in_valid && !drop) state_next = rmsag_pkg::ST_SQUARE;
      end
      rmsag_pkg::ST_SQUARE: begin
        if (cnt == 7'(sq_last)) begin
          state_next = frame_end ? rmsag_pkg::ST_DIV_LOAD : rmsag_pkg::ST_IDLE;
        end
      end
      rmsag_pkg::ST_DIV_LOAD: state_next = rmsag_pkg::ST_DIV;
      rmsag_pkg::ST_DIV: begin
        if (cnt == 7'(rmsag_pkg::DIV_CNT_LAST)) begin
          case (div_sel)
            rmsag_pkg::DIV_DRY: state_next = rmsag_pkg::ST_DIV_LOAD;
            rmsag_pkg::DIV_WET: state_next = rmsag_pkg::ST_SMOOTH;
            default:            state_next = rmsag_pkg::ST_SQRT;
          endcase
        end
      end
      rmsag_pkg::ST_SMOOTH: begin
        if (cnt == 7'd4) state_next = rmsag_pkg::ST_TARGET;
      end
      rmsag_pkg::ST_TARGET: begin
        state_next = (!auto_gain_on || gain_big) ? rmsag_pkg::ST_STEP : rmsag_pkg::ST_DIV_LOAD;
      end
      rmsag_pkg::ST_SQRT: begin
        if (cnt == 7'(rmsag_pkg::ROOT_CNT_LAST)) state_next = rmsag_pkg::ST_STEP;
      end
      rmsag_pkg::ST_STEP: begin
        if (cnt == 7'd1) state_next = rmsag_pkg::ST_HOLD;
      end
      rmsag_pkg::ST_HOLD: begin
        if (out_free) state_next = rmsag_pkg::ST_IDLE;
      end
      default: state_next = rmsag_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == rmsag_pkg::ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      rmsag_pkg::ST_SQUARE: begin
        mul_a = {1'b0, mag[cnt[1:0]]};
        mul_b = MB'(mag[cnt[1:0]]);
      end
      rmsag_pkg::ST_SMOOTH: begin
        case (cnt[1:0])
          2'd0: begin
            mul_a = {1'b0, level_coeff};
            mul_b = dry_mean_square;
          end
          2'd1: begin
            mul_a = (rmsag_pkg::MUL_A_BITS)'(1 << 24) - {1'b0, level_coeff};
            mul_b = dry_mean;
          end
          2'd2: begin
            mul_a = {1'b0, level_coeff};
            mul_b = wet_mean_square;
          end
          default: begin
            mul_a = (rmsag_pkg::MUL_A_BITS)'(1 << 24) - {1'b0, level_coeff};
            mul_b = wet_mean;
          end
        endcase
      end
      rmsag_pkg::ST_STEP: begin
        mul_a = (rmsag_pkg::MUL_A_BITS)'(gain_diff);
        mul_b = MB'(rmsag_pkg::STEP_Q16);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmsag_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 7'd0 : cnt + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_coeff   <= rmsag_pkg::COEFF_RESET;
      auto_gain_on  <= 1'b0;
      delta_on      <= 1'b0;
      channel_count <= 2'd2;
    end else if (cfg_we) begin
      case (rmsag_pkg::reg_index_t'(cfg_index))
        rmsag_pkg::REG_LEVEL_COEFF:   level_coeff   <= cfg_data[rmsag_pkg::COEFF_BITS-1:0];
        rmsag_pkg::REG_AUTO_GAIN_ON:  auto_gain_on  <= cfg_data[0];
        rmsag_pkg::REG_DELTA_ON:      delta_on      <= cfg_data[0];
        rmsag_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_square_sum  <= '0;
      wet_square_sum  <= '0;
      frame_count     <= '0;
      dry_mean_square <= rmsag_pkg::MS_RESET;
      wet_mean_square <= rmsag_pkg::MS_RESET;
      smoothed_gain   <= rmsag_pkg::GAIN_ONE;
      out_valid       <= 1'b0;
      div_sel         <= rmsag_pkg::DIV_DRY;
    end else begin
      if (out_valid && out_ready && (state != rmsag_pkg::ST_HOLD)) out_valid <= 1'b0;
      case (state)
        rmsag_pkg::ST_IDLE: begin
          if (in_fire) begin
            mag[0]    <= magnitude(dry_left);
            mag[1]    <= magnitude(wet_left);
            mag[2]    <= magnitude(dry_right);
            mag[3]    <= magnitude(wet_right);
            frame_end <= block_end;
            stereo    <= channel_count[1];
          end
        end
        rmsag_pkg::ST_SQUARE: begin
          if (cnt != 7'd0) begin
            if (!acc_idx[0]) begin
              dry_square_sum <= dry_square_sum + rmsag_pkg::SUM_BITS'(prod);
            end else begin
              wet_square_sum <= wet_square_sum + rmsag_pkg::SUM_BITS'(prod);
            end
          end
          if (cnt == 7'(sq_last)) begin
            div_sel <= rmsag_pkg::DIV_DRY;
            if (!frame_end) frame_count <= frame_count + 1'b1;
          end
        end
        rmsag_pkg::ST_DIV_LOAD: begin
          div_rem <= '0;
          case (div_sel)
            rmsag_pkg::DIV_DRY: begin
              div_quo <= dry_square_sum >> rmsag_pkg::SUM_SHIFT;
              div_den <= MB'(block_div);
            end
            rmsag_pkg::DIV_WET: begin
              div_quo <= wet_square_sum >> rmsag_pkg::SUM_SHIFT;
              div_den <= MB'(block_div);
            end
            default: begin
              div_quo <= {dry_mean_square, MB'(0)};
              div_den <= wet_den;
            end
          endcase
        end
        rmsag_pkg::ST_DIV: begin
          if (cnt == 7'(rmsag_pkg::DIV_CNT_LAST)) begin
            case (div_sel)
              rmsag_pkg::DIV_DRY: begin
                dry_mean <= mean_sat;
                div_sel  <= rmsag_pkg::DIV_WET;
              end
              rmsag_pkg::DIV_WET: wet_mean <= mean_sat;
              default: begin
                sq_v <= div_quo[QB-1:0];
                sq_r <= '0;
                sq_b <= RB'(1) << (QB - 2);
              end
            endcase
          end else begin
            div_rem <= div_rem_next;
            div_quo <= {div_quo[rmsag_pkg::SUM_BITS-2:0], div_bit};
          end
        end
        rmsag_pkg::ST_SMOOTH: begin
          case (cnt[2:0])
            3'd1, 3'd3: acc <= prod;
            3'd2: dry_mean_square <= smooth_sum[24 +: MB];
            3'd4: wet_mean_square <= smooth_sum[24 +: MB];
            default: ;
          endcase
        end
        rmsag_pkg::ST_TARGET: begin
          target  <= !auto_gain_on ? rmsag_pkg::GAIN_ONE : rmsag_pkg::GAIN_MAX;
          div_sel <= rmsag_pkg::DIV_RATIO;
        end
        rmsag_pkg::ST_SQRT: begin
          if (sq_take) sq_v <= sq_v - sq_rb[QB-1:0];
          sq_r <= sq_r_next;
          sq_b <= sq_b >> 2;
          if (cnt == 7'(rmsag_pkg::ROOT_CNT_LAST)) target <= root_clamped;
        end
        rmsag_pkg::ST_STEP: begin
          if (cnt == 7'd1) begin
            smoothed_gain  <= smoothed_gain + step_shift[GB-1:0];
            dry_square_sum <= '0;
            wet_square_sum <= '0;
            frame_count    <= '0;
          end
        end
        rmsag_pkg::ST_HOLD: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            match_gain <= smoothed_gain;
            apply_gain <= auto_gain_on && !delta_on;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
